// ===== sv/circle_pair_collision_response_assert.svh =====
// Assertion macros for the circle pair collision response block.
`ifndef CIRCLE_PAIR_COLLISION_RESPONSE_ASSERT_SVH
`define CIRCLE_PAIR_COLLISION_RESPONSE_ASSERT_SVH

`ifndef SYNTHESIS
`define CPCR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CPCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CPCR_ASSERT_IMPLY(label, ante, cons, msg)
`define CPCR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== sv/cpcr_pkg.sv =====
package cpcr_pkg;

    localparam int COORD_W    = 32;
    localparam int MASS_W     = 24;
    localparam int RAD_W      = 16;
    localparam int NORM_FRAC  = 14;
    localparam int RS_W       = RAD_W + 1 + 8;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SAT_W      = 42;

    localparam int SQRT_IN_W  = 64;
    localparam int SQRT_OUT_W = 32;
    localparam int SQRT_LAT   = SQRT_OUT_W;

    localparam int DIV_NUM_W  = 58;
    localparam int DIV_DEN_W  = 33;
    localparam int DIV_QUO_W  = 26;
    localparam int DIV_LAT    = DIV_QUO_W + 1;

    localparam int TAIL_LEN   = 8;
    localparam int LATENCY    = 6 + SQRT_LAT + DIV_LAT + 9;

    localparam logic [36:0] VN_LIM = 37'd1 << COORD_W;

    localparam logic [1:0] ST_NONE       = 2'd0;
    localparam logic [1:0] ST_RESOLVED   = 2'd1;
    localparam logic [1:0] ST_COINCIDENT = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] p1x;
        logic signed [COORD_W-1:0] p1y;
        logic signed [COORD_W-1:0] v1x;
        logic signed [COORD_W-1:0] v1y;
        logic signed [COORD_W-1:0] p2x;
        logic signed [COORD_W-1:0] p2y;
        logic signed [COORD_W-1:0] v2x;
        logic signed [COORD_W-1:0] v2y;
        logic [MASS_W-1:0]         m1;
        logic [MASS_W-1:0]         m2;
        logic [RS_W-1:0]           rs;
        logic signed [DIFF_W-1:0]  dvx;
        logic signed [DIFF_W-1:0]  dvy;
        logic [RS_W-1:0]           adx;
        logic [RS_W-1:0]           ady;
        logic                      sdx;
        logic                      sdy;
        logic                      hit;
        logic                      coin;
    } ctx_t;

    typedef struct packed {
        logic [14:0]        nxm;
        logic [14:0]        nym;
        logic signed [26:0] sx;
        logic signed [26:0] sy;
        logic [16:0]        k1;
        logic [16:0]        k2;
    } aux_t;

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
        if (v > $signed(42'h0_7FFF_FFFF))
            return 32'h7FFF_FFFF;
        else if (v < $signed(42'h3FF_8000_0000))
            return 32'h8000_0000;
        else
            return v[COORD_W-1:0];
    endfunction

endpackage

// ===== sv/circle_pair_collision_response.sv =====
// done is start carried through the valid shift register, the same for every pair;
// the result is taken while done is high.
// Throughput: one transaction per cycle; busy stays low and the receiver cannot stall.
// Depth is set by the 32-stage square root and the 26-stage dividers plus rounding.
// Reset (rst_n low, asynchronous) clears the valid bits; no done strobe follows
// for a transaction still in flight at reset.
`include "circle_pair_collision_response_assert.svh"

module circle_pair_collision_response (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] first_pos_x,
    input  logic signed [31:0] first_pos_y,
    input  logic signed [31:0] first_vel_x,
    input  logic signed [31:0] first_vel_y,
    input  logic [23:0]        first_mass,
    input  logic [15:0]        first_radius,
    input  logic signed [31:0] second_pos_x,
    input  logic signed [31:0] second_pos_y,
    input  logic signed [31:0] second_vel_x,
    input  logic signed [31:0] second_vel_y,
    input  logic [23:0]        second_mass,
    input  logic [15:0]        second_radius,
    output logic               done,
    output logic signed [31:0] new_first_pos_x,
    output logic signed [31:0] new_first_pos_y,
    output logic signed [31:0] new_first_vel_x,
    output logic signed [31:0] new_first_vel_y,
    output logic signed [31:0] new_second_pos_x,
    output logic signed [31:0] new_second_pos_y,
    output logic signed [31:0] new_second_vel_x,
    output logic signed [31:0] new_second_vel_y,
    output logic [1:0]         contact_status
);

    logic [cpcr_pkg::LATENCY-1:0] vld_reg;

    cpcr_pkg::ctx_t c1_reg, c1_next;
    cpcr_pkg::ctx_t c2_reg, c2_next;
    cpcr_pkg::ctx_t c3_reg;
    cpcr_pkg::ctx_t c4_reg, c4_next;
    cpcr_pkg::ctx_t c5_reg;
    cpcr_pkg::ctx_t c6_reg;
    cpcr_pkg::ctx_t c7_next;
    cpcr_pkg::ctx_t ctx_sq_reg   [cpcr_pkg::SQRT_LAT];
    cpcr_pkg::ctx_t ctx_dv_reg   [cpcr_pkg::DIV_LAT];
    cpcr_pkg::ctx_t ctx_tail_reg [cpcr_pkg::TAIL_LEN];
    cpcr_pkg::aux_t aux_tail_reg [cpcr_pkg::TAIL_LEN];
    cpcr_pkg::aux_t aux7_next;

    logic signed [32:0] dx1_reg, dx1_next, dy1_reg, dy1_next;
    logic [32:0]        adx_full, ady_full;
    logic               inr2_reg, inr2_next, inr3_reg;
    logic [49:0]        sqx3_reg, sqy3_reg, rsq3_reg;
    logic [50:0]        d2;
    logic [63:0]        rad4_reg, rad4_next;
    logic [31:0]        root;
    logic [31:0]        ov5_reg, d18_5_reg, d18_6_reg;
    logic [56:0]        prodx6_reg, prody6_reg;
    logic [cpcr_pkg::DIV_DEN_W-1:0] den_n, den_s, den_k;
    logic [cpcr_pkg::DIV_QUO_W:0]   q_nx, q_ny, q_sx, q_sy, q_k1, q_k2;
    logic signed [15:0] nx_s, ny_s;
    logic signed [48:0] pdx8_reg, pdy8_reg;
    logic signed [49:0] vsum9_reg;
    logic [49:0]        vmag;
    logic [36:0]        vr;
    logic [32:0]        vnm10_reg, vnm10_next;
    logic               vneg10_reg, vneg11_reg, vneg12_reg, vneg13_reg, vneg14_reg;
    logic [49:0]        pj1_11_reg, pj2_11_reg;
    logic [35:0]        j1m12_reg, j2m12_reg;
    logic [50:0]        q1x13_reg, q1y13_reg, q2x13_reg, q2y13_reg;
    logic [37:0]        dv1x14_reg, dv1y14_reg, dv2x14_reg, dv2y14_reg;
    logic signed [41:0] dv1x_s, dv1y_s, dv2x_s, dv2y_s;

    logic signed [31:0] o_p1x_reg, o_p1y_reg, o_v1x_reg, o_v1y_reg;
    logic signed [31:0] o_p2x_reg, o_p2y_reg, o_v2x_reg, o_v2y_reg;
    logic signed [31:0] o_p1x_next, o_p1y_next, o_v1x_next, o_v1y_next;
    logic signed [31:0] o_p2x_next, o_p2y_next, o_v2x_next, o_v2y_next;
    logic [1:0]         o_st_reg, o_st_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[cpcr_pkg::LATENCY-2:0], start};
        end
    end

    // Stage 1: differences and radius sum.
    always_comb
    begin
        c1_next      = '0;
        c1_next.p1x  = first_pos_x;
        c1_next.p1y  = first_pos_y;
        c1_next.v1x  = first_vel_x;
        c1_next.v1y  = first_vel_y;
        c1_next.p2x  = second_pos_x;
        c1_next.p2y  = second_pos_y;
        c1_next.v2x  = second_vel_x;
        c1_next.v2y  = second_vel_y;
        c1_next.m1   = first_mass;
        c1_next.m2   = second_mass;
        c1_next.rs   = {17'(first_radius) + 17'(second_radius), 8'b0};
        c1_next.dvx  = 33'(first_vel_x) - 33'(second_vel_x);
        c1_next.dvy  = 33'(first_vel_y) - 33'(second_vel_y);
        dx1_next     = 33'(first_pos_x) - 33'(second_pos_x);
        dy1_next     = 33'(first_pos_y) - 33'(second_pos_y);
    end

    // Stage 2: magnitudes and box test.
    always_comb
    begin
        adx_full  = dx1_reg[32] ? 33'(-dx1_reg) : 33'(dx1_reg);
        ady_full  = dy1_reg[32] ? 33'(-dy1_reg) : 33'(dy1_reg);
        inr2_next = (adx_full <= 33'(c1_reg.rs)) && (ady_full <= 33'(c1_reg.rs));
        c2_next     = c1_reg;
        c2_next.adx = adx_full[cpcr_pkg::RS_W-1:0];
        c2_next.ady = ady_full[cpcr_pkg::RS_W-1:0];
        c2_next.sdx = dx1_reg[32];
        c2_next.sdy = dy1_reg[32];
    end

    // Stage 4: squared distance against squared radius sum.
    always_comb
    begin
        d2           = 51'(sqx3_reg) + 51'(sqy3_reg);
        c4_next      = c3_reg;
        c4_next.hit  = inr3_reg && (d2 <= 51'(rsq3_reg)) && (d2 != '0);
        c4_next.coin = inr3_reg && (d2 <= 51'(rsq3_reg)) && (d2 == '0);
        rad4_next    = 64'({d2, 12'b0});
    end

    always_ff @(posedge clk)
    begin
        c1_reg     <= c1_next;
        dx1_reg    <= dx1_next;
        dy1_reg    <= dy1_next;
        c2_reg     <= c2_next;
        inr2_reg   <= inr2_next;
        c3_reg     <= c2_reg;
        inr3_reg   <= inr2_reg;
        sqx3_reg   <= c2_reg.adx * c2_reg.adx;
        sqy3_reg   <= c2_reg.ady * c2_reg.ady;
        rsq3_reg   <= c2_reg.rs * c2_reg.rs;
        c4_reg     <= c4_next;
        rad4_reg   <= rad4_next;
    end

    cpcr_sqrt u_sqrt (
        .clk      (clk),
        .radicand (rad4_reg),
        .root     (root)
    );

    always_ff @(posedge clk)
    begin
        ctx_sq_reg[0] <= c4_reg;
        for (int i = 1; i < cpcr_pkg::SQRT_LAT; i++)
        begin
            ctx_sq_reg[i] <= ctx_sq_reg[i-1];
        end
        c5_reg     <= ctx_sq_reg[cpcr_pkg::SQRT_LAT-1];
        ov5_reg    <= 32'({ctx_sq_reg[cpcr_pkg::SQRT_LAT-1].rs, 6'b0}) - root;
        d18_5_reg  <= root;
        c6_reg     <= c5_reg;
        d18_6_reg  <= d18_5_reg;
        prodx6_reg <= ov5_reg * c5_reg.adx;
        prody6_reg <= ov5_reg * c5_reg.ady;
    end

    assign den_n = cpcr_pkg::DIV_DEN_W'(d18_6_reg);
    assign den_s = {d18_6_reg, 1'b0};
    assign den_k = cpcr_pkg::DIV_DEN_W'(25'(c6_reg.m1) + 25'(c6_reg.m2));

    cpcr_div u_div_nx (
        .clk   (clk),
        .numer (cpcr_pkg::DIV_NUM_W'({c6_reg.adx, 20'b0})),
        .denom (den_n),
        .quo   (q_nx)
    );

    cpcr_div u_div_ny (
        .clk   (clk),
        .numer (cpcr_pkg::DIV_NUM_W'({c6_reg.ady, 20'b0})),
        .denom (den_n),
        .quo   (q_ny)
    );

    cpcr_div u_div_sx (
        .clk   (clk),
        .numer (cpcr_pkg::DIV_NUM_W'(prodx6_reg)),
        .denom (den_s),
        .quo   (q_sx)
    );

    cpcr_div u_div_sy (
        .clk   (clk),
        .numer (cpcr_pkg::DIV_NUM_W'(prody6_reg)),
        .denom (den_s),
        .quo   (q_sy)
    );

    cpcr_div u_div_k1 (
        .clk   (clk),
        .numer (cpcr_pkg::DIV_NUM_W'({c6_reg.m2, 15'b0})),
        .denom (den_k),
        .quo   (q_k1)
    );

    cpcr_div u_div_k2 (
        .clk   (clk),
        .numer (cpcr_pkg::DIV_NUM_W'({c6_reg.m1, 15'b0})),
        .denom (den_k),
        .quo   (q_k2)
    );

    // Stage 7: normal magnitudes, signed push and mass weights.
    always_comb
    begin
        c7_next       = ctx_dv_reg[cpcr_pkg::DIV_LAT-1];
        aux7_next.nxm = q_nx[14:0];
        aux7_next.nym = q_ny[14:0];
        aux7_next.sx  = c7_next.sdx ? -$signed({1'b0, q_sx[25:0]})
                                    : $signed({1'b0, q_sx[25:0]});
        aux7_next.sy  = c7_next.sdy ? -$signed({1'b0, q_sy[25:0]})
                                    : $signed({1'b0, q_sy[25:0]});
        if (c7_next.m1 == '0 && c7_next.m2 == '0)
        begin
            aux7_next.k1 = '0;
            aux7_next.k2 = '0;
        end
        else
        begin
            aux7_next.k1 = q_k1[16:0];
            aux7_next.k2 = q_k2[16:0];
        end
    end

    always_comb
    begin
        nx_s = ctx_tail_reg[0].sdx ? -$signed({1'b0, aux_tail_reg[0].nxm})
                                   : $signed({1'b0, aux_tail_reg[0].nxm});
        ny_s = ctx_tail_reg[0].sdy ? -$signed({1'b0, aux_tail_reg[0].nym})
                                   : $signed({1'b0, aux_tail_reg[0].nym});
        vmag = vsum9_reg[49] ? 50'(-vsum9_reg) : 50'(vsum9_reg);
        vr   = 37'(vmag[49:14]) + 37'(vmag[13]);
        vnm10_next = (vr > cpcr_pkg::VN_LIM) ? cpcr_pkg::VN_LIM[32:0] : vr[32:0];
    end

    always_ff @(posedge clk)
    begin
        ctx_dv_reg[0] <= c6_reg;
        for (int i = 1; i < cpcr_pkg::DIV_LAT; i++)
        begin
            ctx_dv_reg[i] <= ctx_dv_reg[i-1];
        end
        ctx_tail_reg[0] <= c7_next;
        aux_tail_reg[0] <= aux7_next;
        for (int i = 1; i < cpcr_pkg::TAIL_LEN; i++)
        begin
            ctx_tail_reg[i] <= ctx_tail_reg[i-1];
            aux_tail_reg[i] <= aux_tail_reg[i-1];
        end
        pdx8_reg   <= ctx_tail_reg[0].dvx * nx_s;
        pdy8_reg   <= ctx_tail_reg[0].dvy * ny_s;
        vsum9_reg  <= 50'(pdx8_reg) + 50'(pdy8_reg);
        vnm10_reg  <= vnm10_next;
        vneg10_reg <= vsum9_reg[49];
        pj1_11_reg <= vnm10_reg * aux_tail_reg[3].k1;
        pj2_11_reg <= vnm10_reg * aux_tail_reg[3].k2;
        vneg11_reg <= vneg10_reg;
        j1m12_reg  <= 36'(pj1_11_reg[49:14]) + 36'(pj1_11_reg[13]);
        j2m12_reg  <= 36'(pj2_11_reg[49:14]) + 36'(pj2_11_reg[13]);
        vneg12_reg <= vneg11_reg;
        q1x13_reg  <= j1m12_reg * aux_tail_reg[5].nxm;
        q1y13_reg  <= j1m12_reg * aux_tail_reg[5].nym;
        q2x13_reg  <= j2m12_reg * aux_tail_reg[5].nxm;
        q2y13_reg  <= j2m12_reg * aux_tail_reg[5].nym;
        vneg13_reg <= vneg12_reg;
        dv1x14_reg <= 38'(q1x13_reg[50:14]) + 38'(q1x13_reg[13]);
        dv1y14_reg <= 38'(q1y13_reg[50:14]) + 38'(q1y13_reg[13]);
        dv2x14_reg <= 38'(q2x13_reg[50:14]) + 38'(q2x13_reg[13]);
        dv2y14_reg <= 38'(q2y13_reg[50:14]) + 38'(q2y13_reg[13]);
        vneg14_reg <= vneg13_reg;
    end

    // Stage 15: apply push and impulse, saturate, pick the outcome.
    always_comb
    begin
        cpcr_pkg::ctx_t c;
        cpcr_pkg::aux_t a;
        c = ctx_tail_reg[cpcr_pkg::TAIL_LEN-1];
        a = aux_tail_reg[cpcr_pkg::TAIL_LEN-1];
        dv1x_s = (vneg14_reg ^ c.sdx) ? -$signed({4'b0, dv1x14_reg})
                                      : $signed({4'b0, dv1x14_reg});
        dv1y_s = (vneg14_reg ^ c.sdy) ? -$signed({4'b0, dv1y14_reg})
                                      : $signed({4'b0, dv1y14_reg});
        dv2x_s = (vneg14_reg ^ c.sdx) ? -$signed({4'b0, dv2x14_reg})
                                      : $signed({4'b0, dv2x14_reg});
        dv2y_s = (vneg14_reg ^ c.sdy) ? -$signed({4'b0, dv2y14_reg})
                                      : $signed({4'b0, dv2y14_reg});
        o_p1x_next = c.p1x;
        o_p1y_next = c.p1y;
        o_v1x_next = c.v1x;
        o_v1y_next = c.v1y;
        o_p2x_next = c.p2x;
        o_p2y_next = c.p2y;
        o_v2x_next = c.v2x;
        o_v2y_next = c.v2y;
        o_st_next  = cpcr_pkg::ST_NONE;
        if (c.hit)
        begin
            o_p1x_next = cpcr_pkg::sat_coord(42'(c.p1x) + 42'(a.sx));
            o_p1y_next = cpcr_pkg::sat_coord(42'(c.p1y) + 42'(a.sy));
            o_p2x_next = cpcr_pkg::sat_coord(42'(c.p2x) - 42'(a.sx));
            o_p2y_next = cpcr_pkg::sat_coord(42'(c.p2y) - 42'(a.sy));
            o_v1x_next = cpcr_pkg::sat_coord(42'(c.v1x) - dv1x_s);
            o_v1y_next = cpcr_pkg::sat_coord(42'(c.v1y) - dv1y_s);
            o_v2x_next = cpcr_pkg::sat_coord(42'(c.v2x) + dv2x_s);
            o_v2y_next = cpcr_pkg::sat_coord(42'(c.v2y) + dv2y_s);
            o_st_next  = cpcr_pkg::ST_RESOLVED;
        end
        else if (c.coin)
        begin
            o_st_next  = cpcr_pkg::ST_COINCIDENT;
        end
    end

    always_ff @(posedge clk)
    begin
        o_p1x_reg <= o_p1x_next;
        o_p1y_reg <= o_p1y_next;
        o_v1x_reg <= o_v1x_next;
        o_v1y_reg <= o_v1y_next;
        o_p2x_reg <= o_p2x_next;
        o_p2y_reg <= o_p2y_next;
        o_v2x_reg <= o_v2x_next;
        o_v2y_reg <= o_v2y_next;
        o_st_reg  <= o_st_next;
    end

    assign done             = vld_reg[cpcr_pkg::LATENCY-1];
    assign new_first_pos_x  = o_p1x_reg;
    assign new_first_pos_y  = o_p1y_reg;
    assign new_first_vel_x  = o_v1x_reg;
    assign new_first_vel_y  = o_v1y_reg;
    assign new_second_pos_x = o_p2x_reg;
    assign new_second_pos_y = o_p2y_reg;
    assign new_second_vel_x = o_v2x_reg;
    assign new_second_vel_y = o_v2y_reg;
    assign contact_status   = o_st_reg;

    `CPCR_ASSERT_IMPLY(a_status_code, done,
        (contact_status == cpcr_pkg::ST_NONE || contact_status == cpcr_pkg::ST_RESOLVED
         || contact_status == cpcr_pkg::ST_COINCIDENT),
        "Done transaction carries an undefined contact status.")
    `CPCR_ASSERT_IMPLY(a_done_origin, done, $past(start, cpcr_pkg::LATENCY),
        "Done strobe without a matching accepted transaction.")
    `CPCR_ASSERT_IMPLY(a_pass_through, done && contact_status != cpcr_pkg::ST_RESOLVED,
        (new_first_pos_x == $past(first_pos_x, cpcr_pkg::LATENCY)
         && new_second_vel_y == $past(second_vel_y, cpcr_pkg::LATENCY)),
        "Unresolved transaction did not pass its values through.")
    `CPCR_ASSERT_NEXT(a_capture, start, vld_reg[0], "Accepted transaction did not enter the pipeline.")

endmodule

// ===== sv/cpcr_sqrt.sv =====
module cpcr_sqrt (
    input  logic                                clk,
    input  logic [cpcr_pkg::SQRT_IN_W-1:0]      radicand,
    output logic [cpcr_pkg::SQRT_OUT_W-1:0]     root
);

    logic [cpcr_pkg::SQRT_IN_W-1:0]  rem_reg [cpcr_pkg::SQRT_OUT_W];
    logic [cpcr_pkg::SQRT_OUT_W-1:0] q_reg   [cpcr_pkg::SQRT_OUT_W];

    genvar i;
    for (i = 0; i < cpcr_pkg::SQRT_OUT_W; i++)
    begin : g_stage
        localparam int K = cpcr_pkg::SQRT_OUT_W - 1 - i;
        logic [cpcr_pkg::SQRT_IN_W-1:0]  rem_in;
        logic [cpcr_pkg::SQRT_OUT_W-1:0] q_in;
        logic [cpcr_pkg::SQRT_IN_W:0]    trial;
        logic [cpcr_pkg::SQRT_IN_W-1:0]  rem_next;
        logic [cpcr_pkg::SQRT_OUT_W-1:0] q_next;

        if (i == 0)
        begin : g_first
            assign rem_in = radicand;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign q_in   = q_reg[i-1];
        end

        // Trial subtrahend is 2*q*2^K + 2^(2K) for the root bit at position K.
        assign trial = ((cpcr_pkg::SQRT_IN_W+1)'(q_in) << (K + 1))
                     | ((cpcr_pkg::SQRT_IN_W+1)'(1) << (2 * K));

        always_comb
        begin
            if ({1'b0, rem_in} >= trial)
            begin
                rem_next = rem_in - trial[cpcr_pkg::SQRT_IN_W-1:0];
                q_next   = q_in | (cpcr_pkg::SQRT_OUT_W'(1) << K);
            end
            else
            begin
                rem_next = rem_in;
                q_next   = q_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= rem_next;
            q_reg[i]   <= q_next;
        end
    end

    assign root = q_reg[cpcr_pkg::SQRT_OUT_W-1];

endmodule

// ===== sv/cpcr_div.sv =====
module cpcr_div (
    input  logic                                clk,
    input  logic [cpcr_pkg::DIV_NUM_W-1:0]      numer,
    input  logic [cpcr_pkg::DIV_DEN_W-1:0]      denom,
    output logic [cpcr_pkg::DIV_QUO_W:0]        quo
);

    logic [cpcr_pkg::DIV_NUM_W-1:0] rem_reg [cpcr_pkg::DIV_QUO_W];
    logic [cpcr_pkg::DIV_DEN_W-1:0] den_reg [cpcr_pkg::DIV_QUO_W];
    logic [cpcr_pkg::DIV_QUO_W-1:0] q_reg   [cpcr_pkg::DIV_QUO_W];
    logic [cpcr_pkg::DIV_QUO_W:0]   quo_reg;
    logic [cpcr_pkg::DIV_QUO_W:0]   quo_next;

    genvar i;
    for (i = 0; i < cpcr_pkg::DIV_QUO_W; i++)
    begin : g_stage
        localparam int B = cpcr_pkg::DIV_QUO_W - 1 - i;
        logic [cpcr_pkg::DIV_NUM_W-1:0] rem_in;
        logic [cpcr_pkg::DIV_DEN_W-1:0] den_in;
        logic [cpcr_pkg::DIV_QUO_W-1:0] q_in;
        logic [cpcr_pkg::DIV_NUM_W-1:0] sub;
        logic [cpcr_pkg::DIV_NUM_W-1:0] rem_next;
        logic [cpcr_pkg::DIV_QUO_W-1:0] q_next;

        if (i == 0)
        begin : g_first
            assign rem_in = numer;
            assign den_in = denom;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign q_in   = q_reg[i-1];
        end

        assign sub = cpcr_pkg::DIV_NUM_W'(den_in) << B;

        always_comb
        begin
            if (rem_in >= sub)
            begin
                rem_next = rem_in - sub;
                q_next   = q_in | (cpcr_pkg::DIV_QUO_W'(1) << B);
            end
            else
            begin
                rem_next = rem_in;
                q_next   = q_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= rem_next;
            den_reg[i] <= den_in;
            q_reg[i]   <= q_next;
        end
    end

    // Round to nearest with ties away from zero.
    always_comb
    begin
        quo_next = {1'b0, q_reg[cpcr_pkg::DIV_QUO_W-1]};
        if ({rem_reg[cpcr_pkg::DIV_QUO_W-1], 1'b0}
                >= (cpcr_pkg::DIV_NUM_W+1)'(den_reg[cpcr_pkg::DIV_QUO_W-1]))
        begin
            quo_next = quo_next + (cpcr_pkg::DIV_QUO_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

// ===== bench/circle_pair_collision_response_checker.sv =====
module circle_pair_collision_response_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] first_pos_x,
    input  logic signed [31:0] first_pos_y,
    input  logic signed [31:0] first_vel_x,
    input  logic signed [31:0] first_vel_y,
    input  logic [23:0]        first_mass,
    input  logic [15:0]        first_radius,
    input  logic signed [31:0] second_pos_x,
    input  logic signed [31:0] second_pos_y,
    input  logic signed [31:0] second_vel_x,
    input  logic signed [31:0] second_vel_y,
    input  logic [23:0]        second_mass,
    input  logic [15:0]        second_radius,
    input  logic               done,
    input  logic signed [31:0] new_first_pos_x,
    input  logic signed [31:0] new_first_pos_y,
    input  logic signed [31:0] new_first_vel_x,
    input  logic signed [31:0] new_first_vel_y,
    input  logic signed [31:0] new_second_pos_x,
    input  logic signed [31:0] new_second_pos_y,
    input  logic signed [31:0] new_second_vel_x,
    input  logic signed [31:0] new_second_vel_y,
    input  logic [1:0]         contact_status,
    output int                 failures,
    output int                 pending
);

    typedef struct {
        logic signed [31:0] vals [8];
        logic [1:0]         status;
    } collision_t;

    collision_t responses_due [$];

    function automatic logic [127:0] magnitude(input logic signed [127:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [127:0] round_div(input logic signed [127:0] num,
                                                      input logic [127:0] den);
        logic [127:0] a;
        logic [127:0] q;
        a = magnitude(num);
        q = a / den;
        if ((a % den) * 2 >= den)
            q = q + 1;
        return num < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [127:0] round_shift(input logic signed [127:0] a,
                                                        input logic signed [127:0] b);
        logic [127:0] p;
        logic [127:0] q;
        p = magnitude(a) * magnitude(b);
        q = (p >> cpcr_pkg::NORM_FRAC) + ((p >> (cpcr_pkg::NORM_FRAC - 1)) & 1);
        return ((a < 0) != (b < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [127:0] int_sqrt(input logic [127:0] v);
        logic [127:0] r;
        logic [127:0] b;
        r = 0;
        b = 128'd1 << 126;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -128'sh8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic collision_t resolve_pair();
        collision_t r;
        logic signed [127:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
        logic signed [127:0] dx, dy, rs, d18, ov, nx, ny, sx, sy, vn, k1, k2, j1, j2, lim;
        logic [127:0] d2, ms;
        p1x = first_pos_x;  p1y = first_pos_y;  v1x = first_vel_x;  v1y = first_vel_y;
        p2x = second_pos_x; p2y = second_pos_y; v2x = second_vel_x; v2y = second_vel_y;
        dx = p1x - p2x;
        dy = p1y - p2y;
        rs = ($signed({112'd0, first_radius}) + $signed({112'd0, second_radius})) <<< 8;
        r.status = cpcr_pkg::ST_NONE;
        if (magnitude(dx) <= rs && magnitude(dy) <= rs)
        begin
            d2 = magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy);
            if (d2 <= rs * rs)
            begin
                if (d2 == 0)
                    r.status = cpcr_pkg::ST_COINCIDENT;
                else
                begin
                    d18 = int_sqrt(d2 << 12);
                    ov = (rs <<< 6) - d18;
                    nx = round_div(dx <<< 20, d18);
                    ny = round_div(dy <<< 20, d18);
                    sx = round_div(ov * dx, 2 * d18);
                    sy = round_div(ov * dy, 2 * d18);
                    p1x = p1x + sx; p1y = p1y + sy;
                    p2x = p2x - sx; p2y = p2y - sy;
                    vn = (v1x - v2x) * nx + (v1y - v2y) * ny;
                    vn = round_shift(vn, 1);
                    lim = 128'sd1 <<< 32;
                    if (vn > lim)
                        vn = lim;
                    if (vn < -lim)
                        vn = -lim;
                    ms = first_mass + second_mass;
                    k1 = round_div((128'd2 * second_mass) << cpcr_pkg::NORM_FRAC, ms);
                    k2 = round_div((128'd2 * first_mass) << cpcr_pkg::NORM_FRAC, ms);
                    j1 = round_shift(vn, k1);
                    j2 = round_shift(vn, k2);
                    v1x = v1x - round_shift(j1, nx);
                    v1y = v1y - round_shift(j1, ny);
                    v2x = v2x + round_shift(j2, nx);
                    v2y = v2y + round_shift(j2, ny);
                    r.status = cpcr_pkg::ST_RESOLVED;
                end
            end
        end
        r.vals[0] = clamp32(p1x); r.vals[1] = clamp32(p1y);
        r.vals[2] = clamp32(v1x); r.vals[3] = clamp32(v1y);
        r.vals[4] = clamp32(p2x); r.vals[5] = clamp32(p2y);
        r.vals[6] = clamp32(v2x); r.vals[7] = clamp32(v2y);
        return r;
    endfunction

    assign pending = responses_due.size();

    always @(posedge clk)
    begin
        collision_t want;
        logic signed [31:0] got [8];
        logic mismatch;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{new_first_pos_x, new_first_pos_y, new_first_vel_x, new_first_vel_y,
                        new_second_pos_x, new_second_pos_y, new_second_vel_x,
                        new_second_vel_y};
                if (responses_due.size() == 0)
                begin
                    failures = failures + 1;
                    if (failures <= 10)
                        $display("ERROR: transaction result with none expected");
                end
                else
                begin
                    want = responses_due.pop_front();
                    mismatch = (want.status != contact_status);
                    for (int i = 0; i < 8; i++)
                        if (want.vals[i] !== got[i])
                            mismatch = 1'b1;
                    if (mismatch)
                    begin
                        failures = failures + 1;
                        if (failures <= 10)
                        begin
                            $display("ERROR: status exp %0d got %0d", want.status,
                                     contact_status);
                            for (int i = 0; i < 8; i++)
                                $display("  field %0d exp %0d got %0d", i, want.vals[i],
                                         got[i]);
                        end
                    end
                end
            end
            if (start && !busy)
                responses_due.push_back(resolve_pair());
        end
    end

endmodule

// ===== bench/circle_pair_collision_response_tb.sv =====
module circle_pair_collision_response_tb;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] first_pos_x = '0, first_pos_y = '0;
    logic signed [31:0] first_vel_x = '0, first_vel_y = '0;
    logic [23:0]        first_mass = 24'd1;
    logic [15:0]        first_radius = '0;
    logic signed [31:0] second_pos_x = '0, second_pos_y = '0;
    logic signed [31:0] second_vel_x = '0, second_vel_y = '0;
    logic [23:0]        second_mass = 24'd1;
    logic [15:0]        second_radius = '0;
    logic               done;
    logic signed [31:0] new_first_pos_x, new_first_pos_y, new_first_vel_x, new_first_vel_y;
    logic signed [31:0] new_second_pos_x, new_second_pos_y, new_second_vel_x, new_second_vel_y;
    logic [1:0]         contact_status;
    int                 failures;
    int                 pending;
    int                 cycles = 0;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 200000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    circle_pair_collision_response i_dut (.*);

    circle_pair_collision_response_checker i_checker (.*);

    function automatic logic signed [31:0] any_word();
        case ($urandom_range(0, 4))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] any_mass();
        case ($urandom_range(0, 3))
            0: return 24'd1;
            1: return 24'hFFFFFF;
            default: return $urandom_range(1, 24'hFFFFFF);
        endcase
    endfunction

    task automatic send_pair(input logic signed [31:0] p1x, p1y, v1x, v1y,
                             input logic [23:0] m1, input logic [15:0] r1,
                             input logic signed [31:0] p2x, p2y, v2x, v2y,
                             input logic [23:0] m2, input logic [15:0] r2,
                             input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        first_pos_x <= p1x;  first_pos_y <= p1y;  first_vel_x <= v1x;  first_vel_y <= v1y;
        first_mass <= m1;    first_radius <= r1;
        second_pos_x <= p2x; second_pos_y <= p2y; second_vel_x <= v2x; second_vel_y <= v2y;
        second_mass <= m2;   second_radius <= r2;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_random(input bit may_idle);
        logic signed [31:0] p1x, p1y, p2x, p2y;
        logic [15:0] r1, r2;
        int span;
        r1 = ($urandom_range(0, 9) == 0) ? 16'(any_word()) : 16'($urandom_range(0, 4000));
        r2 = ($urandom_range(0, 9) == 0) ? 16'(any_word()) : 16'($urandom_range(0, 4000));
        p1x = any_word();
        p1y = any_word();
        if ($urandom_range(0, 4) != 0)
        begin
            span = (int'(r1) + int'(r2)) * 256 + 1;
            p1x = $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
            p1y = $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
            p2x = p1x + $signed($urandom_range(0, 2 * span)) - span;
            p2y = p1y + $signed($urandom_range(0, 2 * span)) - span;
        end
        else
        begin
            p2x = any_word();
            p2y = any_word();
        end
        send_pair(p1x, p1y, any_word(), any_word(), any_mass(), r1,
                  p2x, p2y, any_word(), any_word(), any_mass(), r2, may_idle);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_pair(0, 0, 1000, 0, 1, 0, 0, 0, 0, 0, 1, 0, 0);
        send_pair(4096, 0, 4096, 0, 256, 16, 4096, 0, 0, 0, 256, 16, 0);
        send_pair(4096, 0, 4096, 0, 256, 16, 0, 0, -4096, 0, 256, 16, 0);
        send_pair(0, 3000, 100, -200, 24'hFFFFFF, 16'hFFFF, 0, -3000, -50, 70, 1,
                  16'hFFFF, 0);
        send_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                  24'hFFFFFF, 16'hFFFF, 32'sh7FFF_0000, 32'sh7FFF_0000, 32'sh8000_0000,
                  32'sh7FFF_FFFF, 1, 16'hFFFF, 0);
        send_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1,
                  16'hFFFF, 32'sh8000_8000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF, 24'hFFFFFF, 16'hFFFF, 0);
        send_pair(0, 0, 5, 5, 1, 1, 32'sh7FFF_FFFF, 0, 0, 0, 1, 1, 0);
        send_pair(1, 1, -1, -1, 3, 0, 0, 0, 1, 1, 5, 0, 0);
        send_pair(-1, 0, 777, 888, 100, 0, 0, 0, -777, -888, 100, 0, 0);
        send_pair(10, 20, 30, 40, 50, 5, 10, 20, 60, 70, 80, 5, 0);
        send_pair(-32'sd65536, 32'sd65536, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'hFFFFFF,
                  16'h8000, 32'sd65536, -32'sd65536, 32'sh8000_0000, 32'sh8000_0000,
                  24'hFFFFFF, 16'h8000, 0);
        send_pair(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                  24'h555555, 16'h5555, 32'sh5555_5554, 32'shAAAA_AAAB,
                  32'shAAAA_AAAA, 32'sh5555_5555, 24'hAAAAAA, 16'hAAAA, 0);
        for (int i = 0; i < 1400; i++)
            send_random(1);
        for (int i = 0; i < 200; i++)
            send_random(0);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (cpcr_pkg::LATENCY + 10) @(posedge clk);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
